// File: hw/rtl/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 27;
  localparam int unsigned REM_W   = 3;
  localparam int unsigned CONT_W  = 6;

  // lead byte classes
  localparam logic [BYTE_W-1:0] ASCII_MASK  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD2_KEEP  = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_KEEP  = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_KEEP  = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_KEEP   = 8'h3F;

  // continuation bytes still to come after each lead
  localparam logic [REM_W-1:0] MORE_2 = 3'd1;
  localparam logic [REM_W-1:0] MORE_3 = 3'd2;
  localparam logic [REM_W-1:0] MORE_4 = 3'd3;
  localparam logic [REM_W-1:0] MORE_5 = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_char;
    logic            truncated;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

// File: hw/rtl/utf8_byte_stream_decoder.sv
// utf8 byte stream decoder: one byte per transaction in, one code point out per sequence
// an accepted byte reaches out_valid via the input register, then the result register
// throughput: 1 byte per cycle when not stalled; the byte path is one shift/mask stage
// reset (rst_n low, synchronous): both stages empty, decode state idle with no partial value
// out_stall backs up into in_stall in the same cycle, so no transaction is dropped
module utf8_byte_stream_decoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  u8dec_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output u8dec_pkg::out_t out_data
);

  // input register stage
  logic           s1_valid_r, s1_valid_nxt;
  u8dec_pkg::in_t s1_data_r;

  // result register stage
  logic            out_valid_r, out_valid_nxt;
  u8dec_pkg::out_t out_data_r;

  logic            in_acc;
  logic            advance;
  logic            out_free;
  u8dec_pkg::res_t res;

  // result register can take a new value when empty or being drained now
  assign out_free = !out_valid_r || !out_stall;
  // the held byte moves through the decoder whenever a result slot is there
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  u8dec_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_data_r),
    .res   (res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (advance && res.valid) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(advance && res.valid))
    else $error("result overwritten while stalled");
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled without a full pipeline");
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r))
    else $error("held byte lost before decoding");
`endif

endmodule

// File: hw/rtl/u8dec_core.sv
module u8dec_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  u8dec_pkg::in_t  item,
  output u8dec_pkg::res_t res
);

  logic [u8dec_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [u8dec_pkg::CP_W-1:0]  part_r, part_nxt;
  logic [u8dec_pkg::REM_W-1:0] more;
  logic [u8dec_pkg::CP_W-1:0]  lead_val;
  logic [u8dec_pkg::CP_W-1:0]  acc;
  logic [u8dec_pkg::BYTE_W-1:0] b;

  assign b   = item.data_byte;
  assign acc = {part_r[u8dec_pkg::CP_W-u8dec_pkg::CONT_W-1:0],
                b[u8dec_pkg::CONT_W-1:0]};

  // lead byte classification
  always_comb begin
    priority if ((b & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_CODE) begin
      more     = u8dec_pkg::MORE_2;
      lead_val = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD2_KEEP};
    end else if ((b & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_CODE) begin
      more     = u8dec_pkg::MORE_3;
      lead_val = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD3_KEEP};
    end else if ((b & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_CODE) begin
      more     = u8dec_pkg::MORE_4;
      lead_val = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD4_KEEP};
    end else begin
      more     = u8dec_pkg::MORE_5;
      lead_val = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD4_KEEP};
    end
  end

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    res      = '0;
    if (rem_r == '0) begin
      if ((b & u8dec_pkg::ASCII_MASK) == '0) begin
        res.valid           = 1'b1;
        res.data.code_point = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b};
        res.data.last_char  = item.end_of_string;
      end else if (item.end_of_string) begin
        // string ends on a lead byte
        res.valid           = 1'b1;
        res.data.code_point = lead_val;
        res.data.last_char  = 1'b1;
        res.data.truncated  = 1'b1;
        part_nxt            = '0;
      end else begin
        rem_nxt  = more;
        part_nxt = lead_val;
      end
    end else begin
      rem_nxt  = rem_r - 1'b1;
      part_nxt = acc;
      if (rem_r == 3'd1) begin
        res.valid           = 1'b1;
        res.data.code_point = acc;
        res.data.last_char  = item.end_of_string;
        part_nxt            = '0;
      end else if (item.end_of_string) begin
        res.valid           = 1'b1;
        res.data.code_point = acc;
        res.data.last_char  = 1'b1;
        res.data.truncated  = 1'b1;
        rem_nxt             = '0;
        part_nxt            = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      part_r <= '0;
    end else if (step) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

`ifndef SYNTH
  a_eos_idles: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.end_of_string |=> rem_r == '0)
    else $error("state not idle after end of string");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= u8dec_pkg::MORE_5)
    else $error("remaining count out of range");
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.end_of_string |-> res.valid && res.data.last_char)
    else $error("end of string without a final result");
  a_trunc_mid: assert property (@(posedge clk) disable iff (!rst_n)
    res.data.truncated |-> item.end_of_string && rem_r != 3'd1)
    else $error("truncated flag on a completed sequence");
`endif

endmodule
